// ===== rtl/core/lli_pkg.sv =====
// Package with widths, payload types and status codes for the line intersection block.
`default_nettype none
package lli_pkg;
    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int OUT_BITS   = 48;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * DIFF_BITS;
    localparam int SUM_BITS   = PROD_BITS + 1;
    localparam int DEN_BITS   = SUM_BITS + 1;
    localparam int NUM_BITS   = DIFF_BITS + SUM_BITS + FRAC_BITS;
    localparam int REM_BITS   = DEN_BITS + 1;
    localparam int VAL_BITS   = NUM_BITS + 2;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_PARALLEL = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] first_start_x;
        logic signed [COORD_BITS-1:0] first_start_y;
        logic signed [COORD_BITS-1:0] first_end_x;
        logic signed [COORD_BITS-1:0] first_end_y;
        logic signed [COORD_BITS-1:0] second_start_x;
        logic signed [COORD_BITS-1:0] second_start_y;
        logic signed [COORD_BITS-1:0] second_end_x;
        logic signed [COORD_BITS-1:0] second_end_y;
    } t_in;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] cross_x;
        logic signed [OUT_BITS-1:0] cross_y;
        logic        [1:0]          status;
    } t_out;

    // Values that ride along with the divider.
    typedef struct packed {
        logic signed [COORD_BITS-1:0] base_x;
        logic signed [COORD_BITS-1:0] base_y;
        logic                         neg_x;
        logic                         neg_y;
        logic                         parallel;
    } t_side;
endpackage
`default_nettype wire

// ===== rtl/core/line_line_intersection.sv =====
// Top level of the two-line intersection pipeline.
`default_nettype none
// Channel | Direction | Handshake                 | Payload
// input   | in        | i_in_valid / o_in_ready   | i_in  (lli_pkg::t_in)
// output  | out       | o_out_valid / i_out_ready | o_out (lli_pkg::t_out)
//
// One transaction can enter every cycle unless the pipeline stalls; the divider
// resolves one quotient bit per stage.
// Reset clears all valid bits; payload registers are not reset.
// The whole pipeline advances together; when the output register holds an
// untaken result, every stage holds and o_in_ready is low.
module line_line_intersection (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_in_valid,
    output logic          o_in_ready,
    input  lli_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  wire           i_out_ready,
    output lli_pkg::t_out o_out
);
    import lli_pkg::*;

    localparam logic signed [VAL_BITS-1:0] SAT_HI =
        VAL_BITS'((longint'(1) <<< (OUT_BITS - 1)) - 1);
    localparam logic signed [VAL_BITS-1:0] SAT_LO = ~SAT_HI;

    function automatic logic signed [DIFF_BITS-1:0] sub_ext(
        input logic signed [COORD_BITS-1:0] a, input logic signed [COORD_BITS-1:0] b);
        return DIFF_BITS'(a) - DIFF_BITS'(b);
    endfunction

    // The whole pipeline moves when the output slot is free or being emptied.
    logic w_en;
    assign w_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    // Stage 1: coordinate differences.
    logic                         r_v1;
    logic signed [DIFF_BITS-1:0]  r1_d1x, r1_d1y, r1_a2, r1_b2;
    logic signed [DIFF_BITS-1:0]  r1_ux1, r1_uy1, r1_ux2, r1_uy2;
    logic signed [COORD_BITS-1:0] r1_bx, r1_by;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_d1x <= sub_ext(i_in.first_end_x, i_in.first_start_x);
            r1_d1y <= sub_ext(i_in.first_end_y, i_in.first_start_y);
            r1_a2  <= sub_ext(i_in.second_start_y, i_in.second_end_y);
            r1_b2  <= sub_ext(i_in.second_end_x, i_in.second_start_x);
            r1_ux1 <= sub_ext(i_in.first_start_x, i_in.second_start_x);
            r1_uy1 <= sub_ext(i_in.first_start_y, i_in.second_start_y);
            r1_ux2 <= sub_ext(i_in.first_end_x, i_in.second_start_x);
            r1_uy2 <= sub_ext(i_in.first_end_y, i_in.second_start_y);
            r1_bx  <= i_in.first_start_x;
            r1_by  <= i_in.first_start_y;
        end
    end

    // Stage 2: the four products of the line equation.
    logic                         r_v2;
    logic signed [PROD_BITS-1:0]  r2_m1, r2_m2, r2_m3, r2_m4;
    logic signed [DIFF_BITS-1:0]  r2_d1x, r2_d1y;
    logic signed [COORD_BITS-1:0] r2_bx, r2_by;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_m1  <= PROD_BITS'(r1_a2) * PROD_BITS'(r1_ux1);
            r2_m2  <= PROD_BITS'(r1_b2) * PROD_BITS'(r1_uy1);
            r2_m3  <= PROD_BITS'(r1_a2) * PROD_BITS'(r1_ux2);
            r2_m4  <= PROD_BITS'(r1_b2) * PROD_BITS'(r1_uy2);
            r2_d1x <= r1_d1x;
            r2_d1y <= r1_d1y;
            r2_bx  <= r1_bx;
            r2_by  <= r1_by;
        end
    end

    // Stage 3: the line equation at both ends of the first line.
    logic                         r_v3;
    logic signed [SUM_BITS-1:0]   r3_s, r3_e;
    logic signed [DIFF_BITS-1:0]  r3_d1x, r3_d1y;
    logic signed [COORD_BITS-1:0] r3_bx, r3_by;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_s   <= SUM_BITS'(r2_m1) + SUM_BITS'(r2_m2);
            r3_e   <= SUM_BITS'(r2_m3) + SUM_BITS'(r2_m4);
            r3_d1x <= r2_d1x;
            r3_d1y <= r2_d1y;
            r3_bx  <= r2_bx;
            r3_by  <= r2_by;
        end
    end

    // Stage 4: denominator, magnitudes and partial signs.
    logic                         r_v4;
    logic signed [DEN_BITS-1:0]   r4_den;
    logic        [SUM_BITS-1:0]   r4_ms;
    logic        [DIFF_BITS-1:0]  r4_mdx, r4_mdy;
    logic                         r4_nx, r4_ny;
    logic signed [COORD_BITS-1:0] r4_bx, r4_by;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_den <= DEN_BITS'(r3_s) - DEN_BITS'(r3_e);
            r4_ms  <= r3_s[SUM_BITS-1] ? (~r3_s + 1'b1) : r3_s;
            r4_mdx <= r3_d1x[DIFF_BITS-1] ? (~r3_d1x + 1'b1) : r3_d1x;
            r4_mdy <= r3_d1y[DIFF_BITS-1] ? (~r3_d1y + 1'b1) : r3_d1y;
            r4_nx  <= r3_d1x[DIFF_BITS-1] ^ r3_s[SUM_BITS-1];
            r4_ny  <= r3_d1y[DIFF_BITS-1] ^ r3_s[SUM_BITS-1];
            r4_bx  <= r3_bx;
            r4_by  <= r3_by;
        end
    end

    // Stage 5: scaled numerators and divisor magnitude.
    logic                         r_v5;
    logic        [NUM_BITS-1:0]   r5_nmx, r5_nmy;
    logic        [DEN_BITS-1:0]   r5_mden;
    t_side                        r5_side;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_nmx  <= (NUM_BITS'(r4_mdx) * NUM_BITS'(r4_ms)) << FRAC_BITS;
            r5_nmy  <= (NUM_BITS'(r4_mdy) * NUM_BITS'(r4_ms)) << FRAC_BITS;
            r5_mden <= r4_den[DEN_BITS-1] ? (~r4_den + 1'b1) : r4_den;
            r5_side.base_x   <= r4_bx;
            r5_side.base_y   <= r4_by;
            r5_side.neg_x    <= r4_nx ^ r4_den[DEN_BITS-1];
            r5_side.neg_y    <= r4_ny ^ r4_den[DEN_BITS-1];
            r5_side.parallel <= (r4_den == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // Divider stages.
    logic                dv_valid;
    logic [NUM_BITS-1:0] dv_qx, dv_qy;
    t_side               dv_side;

    lli_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v5),
        .i_num_x (r5_nmx),
        .i_num_y (r5_nmy),
        .i_den   (r5_mden),
        .i_side  (r5_side),
        .o_valid (dv_valid),
        .o_quo_x (dv_qx),
        .o_quo_y (dv_qy),
        .o_side  (dv_side)
    );

    // Final stage: sign, add the start point, saturate, and zero the point for parallel lines.
    logic signed [VAL_BITS-1:0] w_qx, w_qy, w_vx, w_vy;
    logic                       w_ox, w_oy;
    t_out                       n_out;

    always_comb begin
        w_qx = $signed({2'b00, dv_qx});
        w_qy = $signed({2'b00, dv_qy});
        if (dv_side.neg_x) begin
            w_qx = -w_qx;
        end
        if (dv_side.neg_y) begin
            w_qy = -w_qy;
        end
        w_vx = (VAL_BITS'(dv_side.base_x) <<< FRAC_BITS) + w_qx;
        w_vy = (VAL_BITS'(dv_side.base_y) <<< FRAC_BITS) + w_qy;
        w_ox = (w_vx > SAT_HI) || (w_vx < SAT_LO);
        w_oy = (w_vy > SAT_HI) || (w_vy < SAT_LO);
        n_out.cross_x = (w_vx > SAT_HI) ? OUT_BITS'(SAT_HI) :
                        (w_vx < SAT_LO) ? OUT_BITS'(SAT_LO) : OUT_BITS'(w_vx);
        n_out.cross_y = (w_vy > SAT_HI) ? OUT_BITS'(SAT_HI) :
                        (w_vy < SAT_LO) ? OUT_BITS'(SAT_LO) : OUT_BITS'(w_vy);
        n_out.status  = (w_ox || w_oy) ? STATUS_OVERFLOW : STATUS_OK;
        if (dv_side.parallel) begin
            n_out.cross_x = '0;
            n_out.cross_y = '0;
            n_out.status  = STATUS_PARALLEL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_en) begin
            o_out_valid <= dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_out <= n_out;
        end
    end

    // A parallel result always carries a zero point.
    a_parallel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status == STATUS_PARALLEL
        |-> o_out.cross_x == '0 && o_out.cross_y == '0)
        else $error("parallel result with nonzero point");

    // Only the three defined status codes leave the block.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.status == STATUS_OK || o_out.status == STATUS_PARALLEL
                        || o_out.status == STATUS_OVERFLOW)
        else $error("undefined status code");

    // The pipeline holds still while the output waits.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_v5) && $stable(dv_valid))
        else $error("pipeline moved during a stall");

    // After reset no result is presented.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");
endmodule
`default_nettype wire

// ===== rtl/core/lli_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, two lanes sharing a divisor.
`default_nettype none
module lli_div (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_en,
    input  wire                           i_valid,
    input  wire  [lli_pkg::NUM_BITS-1:0]  i_num_x,
    input  wire  [lli_pkg::NUM_BITS-1:0]  i_num_y,
    input  wire  [lli_pkg::DEN_BITS-1:0]  i_den,
    input  lli_pkg::t_side                i_side,
    output logic                          o_valid,
    output logic [lli_pkg::NUM_BITS-1:0]  o_quo_x,
    output logic [lli_pkg::NUM_BITS-1:0]  o_quo_y,
    output lli_pkg::t_side                o_side
);
    import lli_pkg::*;

    localparam int W = REM_BITS + NUM_BITS;

    function automatic logic [W-1:0] div_step(input logic [W-1:0] w,
                                              input logic [DEN_BITS-1:0] den);
        logic [W-1:0]        t;
        logic [REM_BITS-1:0] up;
        t  = w << 1;
        up = t[W-1 -: REM_BITS];
        if (up >= {1'b0, den}) begin
            t[W-1 -: REM_BITS] = up - {1'b0, den};
            t[0] = 1'b1;
        end
        return t;
    endfunction

    logic [W-1:0]          r_wx   [NUM_BITS];
    logic [W-1:0]          r_wy   [NUM_BITS];
    logic [DEN_BITS-1:0]   r_den  [NUM_BITS];
    t_side                 r_side [NUM_BITS];
    logic [NUM_BITS-1:0]   r_v;

    for (genvar k = 0; k < NUM_BITS; k++) begin : g_stage
        logic [W-1:0]        wx_in;
        logic [W-1:0]        wy_in;
        logic [DEN_BITS-1:0] d_in;
        t_side               s_in;
        logic                v_in;
        if (k == 0) begin : g_first
            assign wx_in = {{REM_BITS{1'b0}}, i_num_x};
            assign wy_in = {{REM_BITS{1'b0}}, i_num_y};
            assign d_in  = i_den;
            assign s_in  = i_side;
            assign v_in  = i_valid;
        end else begin : g_next
            assign wx_in = r_wx[k-1];
            assign wy_in = r_wy[k-1];
            assign d_in  = r_den[k-1];
            assign s_in  = r_side[k-1];
            assign v_in  = r_v[k-1];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_wx[k]   <= div_step(wx_in, d_in);
                r_wy[k]   <= div_step(wy_in, d_in);
                r_den[k]  <= d_in;
                r_side[k] <= s_in;
            end
        end
    end

    assign o_valid = r_v[NUM_BITS-1];
    assign o_quo_x = r_wx[NUM_BITS-1][NUM_BITS-1:0];
    assign o_quo_y = r_wy[NUM_BITS-1][NUM_BITS-1:0];
    assign o_side  = r_side[NUM_BITS-1];
endmodule
`default_nettype wire
